### rtl/lqs_pkg.sv
`timescale 1ns / 1ps

package lqs_pkg;

   // Widths fixed by the item format
   localparam int OP_W     = 2;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;

   // Request operations
   typedef enum logic [OP_W-1:0] {
      OP_ENQ    = 2'd0,
      OP_DEQ    = 2'd1,
      OP_TRAV   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_ENQ      = 3'd0,
      STAT_OVF      = 3'd1,
      STAT_DEQ      = 3'd2,
      STAT_UNF      = 3'd3,
      STAT_ELEM     = 3'd4,
      STAT_EMPTY    = 3'd5,
      STAT_FOUND    = 3'd6,
      STAT_NOTFOUND = 3'd7
   } status_type;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // Control broadcast from the controller to every cell
   typedef struct packed {
      logic rotate;   // every cell takes its upper neighbor's word
      logic write;    // the addressed cell loads the write word
   } cell_ctrl_type;

endpackage

### rtl/lqs_req_if.sv
`timescale 1ns / 1ps

interface lqs_req_if;
   import lqs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [WORD_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

### rtl/lqs_rsp_if.sv
`timescale 1ns / 1ps

interface lqs_rsp_if;
   import lqs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [WORD_W-1:0] data;
   logic [SLOT_W-1:0]        slot;
   logic                     last;

   modport source (output valid, output status, output data, output slot, output last,
                   input ready);
   modport sink   (input valid, input status, input data, input slot, input last,
                   output ready);
endinterface

### rtl/lqs_cell.sv
`timescale 1ns / 1ps

module lqs_cell
   import lqs_pkg::*;
#(
   parameter int IDX_W   = 4,
   parameter int SLOT_ID = 0
) (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic [IDX_W-1:0]         wr_idx,
   input  logic signed [WORD_W-1:0] wr_data,
   input  logic signed [WORD_W-1:0] next_word,
   output logic signed [WORD_W-1:0] word
);

   logic signed [WORD_W-1:0] word_ff, word_in;
   logic                     wr_hit;

   assign wr_hit = (wr_idx == IDX_W'(SLOT_ID));

   // Rotate along the ring, or take a write aimed at this slot
   always_comb begin
      word_in = word_ff;
      if (ctrl.rotate) begin
         word_in = next_word;
      end else if (ctrl.write && wr_hit) begin
         word_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

### rtl/linear_array_queue_with_search.sv
`timescale 1ns / 1ps

// Linear (non-wrapping) queue of DEPTH signed 32-bit words with traverse and search.
// req_chan (valid/ready) takes one item: op and value. rsp_chan (valid/ready)
// returns the result items, the final one of each request marked by last.
// Enqueue and any request on an empty queue answer at once: the result is
// registered at the edge that accepts the item.
// Dequeue, traverse and search on a non-empty queue rotate the ring of DEPTH word
// cells once around, one slot per cycle past cell 0 while the receiver does not
// stall; no new item is taken until the turn ends, and the ring ends where it started.
// Traverse yields one result per held word, head first; dequeue and search yield one.
// A request is taken only while no scan runs and the result register is free or
// being emptied in that cycle. When rsp_chan stalls, the ring holds still.
// Reset (synchronous, active high) empties the queue and drops any pending
// result; the stored words are not cleared.
module linear_array_queue_with_search
   import lqs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   lqs_req_if.sink    req_chan,
   lqs_rsp_if.source  rsp_chan
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   op_type                   op_ff, op_in;
   logic signed [WORD_W-1:0] key_ff, key_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic                     empty_ff, empty_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_ctrl_type            ctrl;
   logic [IDX_W-1:0]         wr_idx;
   logic signed [WORD_W-1:0] cell_word [DEPTH];

   logic                     out_free;
   logic                     in_range;
   op_type                   req_op;

   // Ring of word cells; cell k takes cell k+1, the top one takes cell 0
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      localparam int NXT = (k + 1) % DEPTH;
      lqs_cell #(
         .IDX_W   (IDX_W),
         .SLOT_ID (k)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .wr_idx    (wr_idx),
         .wr_data   (req_chan.value),
         .next_word (cell_word[NXT]),
         .word      (cell_word[k])
      );
   end

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_op         = op_type'(req_chan.op);
   assign in_range       = (idx_ff >= head_ff) && (idx_ff <= tail_ff);

   // Next state, pointer updates and result loading
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      found_in      = found_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      ctrl          = '0;
      wr_idx        = tail_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid && req_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_slot_in  = '0;
               rsp_last_in  = 1'b1;
               if (req_op == OP_ENQ) begin
                  if (empty_ff) begin
                     ctrl.write    = 1'b1;
                     wr_idx        = '0;
                     head_in       = '0;
                     tail_in       = '0;
                     empty_in      = 1'b0;
                     rsp_status_in = STAT_ENQ;
                  end else if (tail_ff == LAST_IDX) begin
                     rsp_status_in = STAT_OVF;
                  end else begin
                     ctrl.write    = 1'b1;
                     wr_idx        = tail_ff + 1'b1;
                     tail_in       = tail_ff + 1'b1;
                     rsp_status_in = STAT_ENQ;
                  end
               end else if (empty_ff) begin
                  rsp_status_in = (req_op == OP_DEQ) ? STAT_UNF : STAT_EMPTY;
               end else begin
                  // start a full turn of the ring
                  rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
                  state_in     = ST_SCAN;
                  idx_in       = '0;
                  op_in        = req_op;
                  key_in       = req_chan.value;
                  found_in     = 1'b0;
               end
            end
         end

         ST_SCAN: begin
            if (out_free) begin
               ctrl.rotate = 1'b1;
               idx_in      = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
               // cell 0 now holds slot idx_ff
               case (op_ff)
                  OP_DEQ: begin
                     if (idx_ff == head_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_DEQ;
                        rsp_data_in   = cell_word[0];
                        rsp_slot_in   = '0;
                        rsp_last_in   = 1'b1;
                     end
                  end
                  OP_TRAV: begin
                     if (in_range) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_ELEM;
                        rsp_data_in   = cell_word[0];
                        rsp_slot_in   = SLOT_W'(idx_ff);
                        rsp_last_in   = (idx_ff == tail_ff);
                     end
                  end
                  default: begin
                     if (!found_ff && in_range && (cell_word[0] == key_ff)) begin
                        found_in      = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_FOUND;
                        rsp_data_in   = '0;
                        rsp_slot_in   = SLOT_W'(idx_ff);
                        rsp_last_in   = 1'b1;
                     end else if (!found_ff && (idx_ff == LAST_IDX)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_NOTFOUND;
                        rsp_data_in   = '0;
                        rsp_slot_in   = '0;
                        rsp_last_in   = 1'b1;
                     end
                  end
               endcase

               // ring is back in place after the last slot
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
                  if (op_ff == OP_DEQ) begin
                     if (head_ff >= tail_ff) begin
                        head_in  = '0;
                        tail_in  = '0;
                        empty_in = 1'b1;
                     end else begin
                        head_in = head_ff + 1'b1;
                     end
                  end
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.data   = rsp_data_ff;
   assign rsp_chan.slot   = rsp_slot_ff;
   assign rsp_chan.last   = rsp_last_ff;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import lqs_pkg::*;

   localparam int QDEPTH     = 16;
   localparam int RAND_ITEMS = 240;

   // One response item as the queue is expected to return it
   typedef struct {
      status_type               status;
      logic signed [WORD_W-1:0] data;
      logic [SLOT_W-1:0]        slot;
      logic                     last;
   } rsp_item_type;

   // Shadow queue: mirrors the linear array and holds the responses still owed
   class queue_model;
      logic signed [WORD_W-1:0] words [QDEPTH];
      logic [SLOT_W-1:0]        head;
      logic [SLOT_W-1:0]        tail;
      bit                       is_empty;
      rsp_item_type             owed_rsp[$];
      int                       errors;

      function new();
         foreach (words[i]) words[i] = '0;
         head     = '0;
         tail     = '0;
         is_empty = 1'b1;
         errors   = 0;
      endfunction

      function void owe(status_type st, logic signed [WORD_W-1:0] d,
                        logic [SLOT_W-1:0] sl, logic lst);
         rsp_item_type r;
         r.status = st;
         r.data   = d;
         r.slot   = sl;
         r.last   = lst;
         owed_rsp.push_back(r);
      endfunction

      // Apply one accepted request and queue up the responses it causes
      function void take_request(op_type op, logic signed [WORD_W-1:0] value);
         int found;
         found = -1;
         case (op)
            OP_ENQ: begin
               if (is_empty) begin
                  // empty queue always restarts at slot 0
                  head     = '0;
                  tail     = '0;
                  words[0] = value;
                  is_empty = 1'b0;
                  owe(STAT_ENQ, '0, '0, 1'b1);
               end else if (tail == QDEPTH - 1) begin
                  // no wrap: full at the top even if slots below head are free
                  owe(STAT_OVF, '0, '0, 1'b1);
               end else begin
                  tail        = tail + 1'b1;
                  words[tail] = value;
                  owe(STAT_ENQ, '0, '0, 1'b1);
               end
            end
            OP_DEQ: begin
               if (is_empty) begin
                  owe(STAT_UNF, '0, '0, 1'b1);
               end else begin
                  owe(STAT_DEQ, words[head], '0, 1'b1);
                  if (head >= tail) begin
                     head     = '0;
                     tail     = '0;
                     is_empty = 1'b1;
                  end else begin
                     head = head + 1'b1;
                  end
               end
            end
            OP_TRAV: begin
               if (is_empty) begin
                  owe(STAT_EMPTY, '0, '0, 1'b1);
               end else begin
                  for (int i = head; i <= tail; i++)
                     owe(STAT_ELEM, words[i], i[SLOT_W-1:0], (i == tail));
               end
            end
            default: begin
               if (is_empty) begin
                  owe(STAT_EMPTY, '0, '0, 1'b1);
               end else begin
                  // match nearest the head wins
                  for (int i = head; i <= tail; i++)
                     if (found < 0 && words[i] == value) found = i;
                  if (found >= 0) owe(STAT_FOUND, '0, found[SLOT_W-1:0], 1'b1);
                  else owe(STAT_NOTFOUND, '0, '0, 1'b1);
               end
            end
         endcase
      endfunction

      // Compare one accepted response against the oldest owed one
      function void check_response(logic [STATUS_W-1:0] st, logic signed [WORD_W-1:0] d,
                                   logic [SLOT_W-1:0] sl, logic lst);
         rsp_item_type e;
         if (owed_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected response status=%0d data=%0d slot=%0d last=%0b",
                     $time, st, d, sl, lst);
            return;
         end
         e = owed_rsp.pop_front();
         if (st !== e.status || d !== e.data || sl !== e.slot || lst !== e.last) begin
            errors++;
            $display("%0t: mismatch expected status=%0d data=%0d slot=%0d last=%0b",
                     $time, e.status, e.data, e.slot, e.last);
            $display("%0t:          actual   status=%0d data=%0d slot=%0d last=%0b",
                     $time, st, d, sl, lst);
         end
      endfunction

      // A word currently held, for search keys that should hit
      function logic signed [WORD_W-1:0] held_word();
         return words[$urandom_range(int'(tail), int'(head))];
      endfunction
   endclass

   logic clock;
   logic reset;

   lqs_req_if req ();
   lqs_rsp_if rsp ();

   linear_array_queue_with_search #(
      .DEPTH (QDEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   queue_model sb = new();

   int burst_left = 0;
   bit gaps_on    = 1'b1;

   // Receiver stall pattern state
   int       rx_mode     = 0;
   int       mode_cycles = 0;
   bit [7:0] rx_pattern  = 8'hff;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Values lean on the extremes and a small pool so that duplicates occur
   function automatic logic signed [WORD_W-1:0] rand_word();
      case ($urandom_range(5))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return $signed($urandom_range(6)) - 3;
         default: return $urandom;
      endcase
   endfunction

   // Send one request item; called and returns at a falling edge
   task automatic issue(op_type op, logic signed [WORD_W-1:0] value);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         if (gaps_on) begin
            req.valid <= 1'b0;
            req.op    <= OP_W'($urandom);
            req.value <= $urandom;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req.valid <= 1'b1;
      req.op    <= op;
      req.value <= value;
      @(posedge clock);
      while (req.ready !== 1'b1) @(posedge clock);
      sb.take_request(op, value);
      @(negedge clock);
   endtask

   // Response ready: follows one of four modes, picked anew at random
   always @(negedge clock) begin
      if (mode_cycles == 0) begin
         rx_mode     <= $urandom_range(3);
         rx_pattern  <= 8'($urandom);
         mode_cycles <= $urandom_range(20, 80);
      end else begin
         mode_cycles <= mode_cycles - 1;
         if (rx_mode == 3) rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
      end
      case (rx_mode)
         0:       rsp.ready <= 1'b1;
         1:       rsp.ready <= ($urandom_range(3) != 0);
         2:       rsp.ready <= ($urandom_range(3) == 0);
         default: rsp.ready <= rx_pattern[0];
      endcase
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1)
         sb.check_response(rsp.status, rsp.data, rsp.slot, rsp.last);
   end

   // Main sequence
   initial begin
      int       sent;
      int       phase_kind;
      int       phase_len;
      int       r;
      op_type   op;
      logic signed [WORD_W-1:0] value;

      sent      = 0;
      reset     = 1'b1;
      req.valid = 1'b0;
      req.op    = OP_ENQ;
      req.value = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty-queue cases, single-word drain, extremes, duplicates
      issue(OP_TRAV, 32'sd0);
      issue(OP_SEARCH, 32'sd0);
      issue(OP_DEQ, 32'sd0);
      issue(OP_ENQ, -32'sd1);
      issue(OP_DEQ, 32'sd0);
      issue(OP_ENQ, 32'h8000_0000);
      issue(OP_ENQ, 32'h7fff_ffff);
      issue(OP_ENQ, 32'sd0);
      issue(OP_ENQ, 32'h8000_0000);
      issue(OP_SEARCH, 32'h8000_0000);
      issue(OP_SEARCH, 32'sd12345);
      issue(OP_TRAV, 32'sd0);
      issue(OP_DEQ, 32'sd0);
      issue(OP_SEARCH, 32'h8000_0000);
      // fill to the top slot, then overflow with a freed slot below head
      repeat (QDEPTH - 4) issue(OP_ENQ, rand_word());
      issue(OP_ENQ, 32'sd7);
      issue(OP_TRAV, 32'sd0);

      // Random phases: filling, draining and mixed traffic
      while (sent < RAND_ITEMS) begin
         phase_kind = $urandom_range(2);
         phase_len  = $urandom_range(20, 50);
         if (phase_len > RAND_ITEMS - sent) phase_len = RAND_ITEMS - sent;
         gaps_on    = ($urandom_range(3) != 0);
         repeat (phase_len) begin
            r = $urandom_range(99);
            case (phase_kind)
               0:       op = (r < 65) ? OP_ENQ : (r < 75) ? OP_DEQ :
                             (r < 85) ? OP_TRAV : OP_SEARCH;
               1:       op = (r < 15) ? OP_ENQ : (r < 70) ? OP_DEQ :
                             (r < 80) ? OP_TRAV : OP_SEARCH;
               default: op = (r < 35) ? OP_ENQ : (r < 65) ? OP_DEQ :
                             (r < 80) ? OP_TRAV : OP_SEARCH;
            endcase
            if (op == OP_SEARCH && !sb.is_empty && $urandom_range(1))
               value = sb.held_word();
            else if (op == OP_ENQ || op == OP_SEARCH)
               value = rand_word();
            else
               value = $urandom;
            issue(op, value);
            sent++;
         end
      end
      req.valid <= 1'b0;

      // Drain, then a quiet period to catch stray responses
      while (sb.owed_rsp.size() != 0) @(posedge clock);
      repeat (4 * QDEPTH) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #100_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
